[src/dgis_pkg.sv]
// shared types and constants for the depth/gap interval segmenter
// no dependencies; imported by every module of the block
package dgis_pkg;

    localparam int MAX_COLUMNS = 65536;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int FIN_W       = COL_W + 1;
    localparam int POS_W       = 32;
    localparam int DEPTH_W     = 16;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_FLOOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT       = 1'd1;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 40;

    // one half-open column interval
    typedef struct packed {
        logic [COL_W-1:0] res_begin;
        logic [FIN_W-1:0] res_finish;
    } interval_t;

    // work for the back end: one or two intervals caused by one column
    typedef struct packed {
        logic      two;
        interval_t first;
        interval_t second;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

endpackage

[src/dgis_front.sv]
// front end: configuration registers, column classification and interval state
// depends on dgis_pkg; pushes interval entries into dgis_fifo
module dgis_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [dgis_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dgis_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          col_valid,
    input  logic [dgis_pkg::POS_W-1:0]    col_pos,
    input  logic [dgis_pkg::DEPTH_W-1:0]  col_depth,
    input  logic                          col_last,
    input  dgis_pkg::fifo_status_t        fifo_status,
    output logic                          col_ready,
    output logic                          push,
    output dgis_pkg::entry_t              push_entry
);
    import dgis_pkg::*;

    logic [DEPTH_W-1:0] depth_floor_reg;
    logic               split_reg;
    logic [COL_W-1:0]   counter_reg, counter_next;
    logic               open_reg, open_next;
    logic [COL_W-1:0]   start_reg, start_next;
    logic [POS_W-1:0]   prev_reg;

    logic             accept;
    logic             last_eff;
    logic             good;
    logic             gap;
    logic             close_bad;
    logic             split_cut;
    logic             close_last;
    logic [FIN_W-1:0] idx_ext;
    logic [FIN_W-1:0] idx_plus;

    assign col_ready = !fifo_status.full;
    assign accept    = col_valid && col_ready;

    always_comb begin
        idx_ext    = {1'b0, counter_reg};
        idx_plus   = idx_ext + FIN_W'(1);
        last_eff   = col_last || (counter_reg == COL_W'(MAX_COLUMNS - 1));
        good       = (depth_floor_reg == '0) || (col_depth >= depth_floor_reg);
        // unsigned jump > 1, done as an unsigned compare one bit wider
        gap        = split_reg && (counter_reg != '0) &&
                     ({1'b0, col_pos} > ({1'b0, prev_reg} + (POS_W+1)'(1)));
        close_bad  = !good && open_reg;
        split_cut  = good && open_reg && gap;
        open_next  = good;
        start_next = (good && (!open_reg || gap)) ? counter_reg : start_reg;
        close_last = last_eff && open_next;

        push_entry.two = split_cut && close_last;
        if (close_bad || split_cut) begin
            push_entry.first.res_begin  = start_reg;
            push_entry.first.res_finish = idx_ext;
        end else begin
            push_entry.first.res_begin  = start_next;
            push_entry.first.res_finish = idx_plus;
        end
        push_entry.second.res_begin  = start_next;
        push_entry.second.res_finish = idx_plus;

        push         = accept && (close_bad || split_cut || close_last);
        counter_next = last_eff ? '0 : idx_plus[COL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_floor_reg <= '0;
            split_reg       <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DEPTH_FLOOR: depth_floor_reg <= cfg_wdata[DEPTH_W-1:0];
                REG_SPLIT:       split_reg       <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
            open_reg    <= 1'b0;
            start_reg   <= '0;
            prev_reg    <= '0;
        end else if (accept) begin
            counter_reg <= counter_next;
            open_reg    <= open_next && !last_eff;
            start_reg   <= start_next;
            prev_reg    <= col_pos;
        end
    end

endmodule

[src/dgis_fifo.sv]
// short queue of interval entries between front and back end
// depends on dgis_pkg
module dgis_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  dgis_pkg::entry_t       push_entry,
    input  logic                   pop,
    output dgis_pkg::entry_t       head,
    output dgis_pkg::fifo_status_t status
);
    import dgis_pkg::*;

    entry_t             store_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = store_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[src/dgis_back.sv]
// back end: unpacks queue entries into single interval results, output register
// depends on dgis_pkg; reads the head of dgis_fifo
module dgis_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dgis_pkg::entry_t             head,
    input  dgis_pkg::fifo_status_t       fifo_status,
    output logic                         pop,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [dgis_pkg::COL_W-1:0]   out_begin,
    output logic [dgis_pkg::FIN_W-1:0]   out_finish,
    output logic                         out_final
);
    import dgis_pkg::*;

    logic             valid_reg, valid_next;
    logic             sel_reg, sel_next;
    logic [COL_W-1:0] begin_reg;
    logic [FIN_W-1:0] finish_reg;
    logic             final_reg;
    logic             load;
    logic             take;
    interval_t        cur;

    assign load = !valid_reg || out_ready;
    assign take = load && !fifo_status.empty;
    assign cur  = sel_reg ? head.second : head.first;

    always_comb begin
        pop        = take && (!head.two || sel_reg);
        valid_next = load ? !fifo_status.empty : valid_reg;
        sel_next   = sel_reg;
        if (take) begin
            sel_next = !pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            begin_reg  <= cur.res_begin;
            finish_reg <= cur.res_finish;
            final_reg  <= pop;
        end
    end

    assign out_valid  = valid_reg;
    assign out_begin  = begin_reg;
    assign out_finish = finish_reg;
    assign out_final  = final_reg;

`ifndef SYNTHESIS
    // second half of a pair is only pending while its entry is still queued
    a_sel_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg |-> !fifo_status.empty)
        else $error("second result pending with empty queue");

    a_sel_needs_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg |-> head.two)
        else $error("second result pending for a single-result entry");

    // a non-final result taken is always followed by its partner
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && out_ready && !final_reg) |=> valid_reg)
        else $error("partner result missing after non-final result");
`endif

endmodule

[src/depth_gap_interval_segmenter.sv]
// top level of the depth/gap interval segmenter
// depends on dgis_pkg, dgis_front, dgis_fifo, dgis_back
//
//  channel | dir | request                            | handshake
//  --------+-----+------------------------------------+------------------
//  s_      | in  | one pileup column                  | s_tvalid/s_tready
//  m_      | out | one half-open column interval      | m_tvalid/m_tready
//  cfg_    | in  | register write (depth floor, split)| cfg_we, no wait
//
// one column per cycle is accepted while the interval queue has room; a column
// that closes two intervals gives the back end two output results, sent in turn
// a column's first interval passes through the queue, then the output register
// aresetn is synchronous; it clears the column counter, interval state and regs
// the front end stalls only on a full four-entry queue, the back end only on m_tready
module depth_gap_interval_segmenter (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write port
    input  logic                              cfg_we,
    input  logic [dgis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dgis_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // column stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dgis_pkg::S_DATA_W-1:0]     s_tdata,   // position_major, column_depth
    input  logic                              s_tlast,   // last_column
    // interval stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dgis_pkg::M_DATA_W-1:0]     m_tdata,   // interval_begin, interval_finish, pad
    output logic                              m_tlast    // final_of_run
);
    import dgis_pkg::*;

    logic             push, pop;
    entry_t           push_entry, head;
    fifo_status_t     fifo_status;
    logic [COL_W-1:0] interval_begin;
    logic [FIN_W-1:0] interval_finish;

    // classification and interval bookkeeping
    dgis_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .col_valid   (s_tvalid),
        .col_pos     (s_tdata[POS_W-1:0]),
        .col_depth   (s_tdata[POS_W+DEPTH_W-1:POS_W]),
        .col_last    (s_tlast),
        .fifo_status (fifo_status),
        .col_ready   (s_tready),
        .push        (push),
        .push_entry  (push_entry)
    );

    // decoupling queue
    dgis_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (fifo_status)
    );

    // result sequencing and output register
    dgis_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .fifo_status (fifo_status),
        .pop         (pop),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_begin   (interval_begin),
        .out_finish  (interval_finish),
        .out_final   (m_tlast)
    );

    // pack begin then finish, zero pad to whole bytes
    assign m_tdata = {(M_DATA_W-COL_W-FIN_W)'(0), interval_finish, interval_begin};

endmodule
